[src/tcpq_pkg.sv]
// Shared types, sizes and status codes for the two-class priority queue.
package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W = 16;
    localparam int AGE_W = 8;
    localparam int ST_W  = 3;

    localparam logic [AGE_W-1:0] AGE_THRESHOLD_RESET = 8'd60;

    localparam logic [ST_W-1:0] ST_ADD_PRIO   = 3'd0;
    localparam logic [ST_W-1:0] ST_ADD_REG    = 3'd1;
    localparam logic [ST_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [ST_W-1:0] ST_SERVE_PRIO = 3'd3;
    localparam logic [ST_W-1:0] ST_SERVE_REG  = 3'd4;
    localparam logic [ST_W-1:0] ST_NONE       = 3'd5;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [TAG_W-1:0] client_tag;
        logic [AGE_W-1:0] client_age;
        logic             urgent;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [TAG_W-1:0] served_tag;
        logic [AGE_W-1:0] served_age;
        logic             served_urgent;
    } t_out_word;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic             urgent;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

[src/two_class_priority_queue.sv]
// Top level: request register, classification and service logic, result register.
//
// Two first-in first-out queues of QUEUE_DEPTH entries each, served in strict
// priority. An add word goes to the priority queue when its urgent flag is set
// or its age is at or above the age threshold register (reset 60), otherwise to
// the regular queue; an add into a full queue is dropped and reported. A serve
// word pops the priority head, else the regular head, else reports that nothing
// is waiting. Every request word gives exactly one result word. The block takes
// one word per cycle while its request side is not stalled. A request word passes
// through the request register, then the result register together with the
// registered read of the queue memory, before its result word is presented.
// The request side stalls only while a result word is held and not taken. The
// served fields are zero unless a word was served.
// The threshold may be written only while no request is in flight.
module two_class_priority_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    input  tcpq_pkg::t_in_word   i_word,
    output logic                 o_stall,
    // result channel
    output logic                 o_valid,
    output tcpq_pkg::t_out_word  o_word,
    input  logic                 i_stall,
    // threshold register
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);
    import tcpq_pkg::*;

    logic               r_in_valid;
    t_in_word           r_in;
    logic               r_out_valid;
    logic [ST_W-1:0]    r_status;
    logic               r_served;
    logic               r_from_prio;
    logic [AGE_W-1:0]   r_thresh;

    logic               advance;
    logic               to_prio;
    logic               push_prio;
    logic               push_reg;
    logic               pop_prio;
    logic               pop_reg;
    logic [ST_W-1:0]    n_status;
    t_entry             new_entry;
    t_entry             prio_rdata;
    t_entry             reg_rdata;
    t_entry             served_entry;
    t_fifo_stat         prio_stat;
    t_fifo_stat         reg_stat;

    // Advance the held request when the result register is free or being taken.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    assign new_entry.tag    = r_in.client_tag;
    assign new_entry.age    = r_in.client_age;
    assign new_entry.urgent = r_in.urgent;

    assign to_prio = r_in.urgent || (r_in.client_age >= r_thresh);

    // Classify the held request and pick the queue to touch.
    always_comb begin
        push_prio = 1'b0;
        push_reg  = 1'b0;
        pop_prio  = 1'b0;
        pop_reg   = 1'b0;
        n_status  = ST_NONE;
        case (r_in.action)
            ACT_ADD: begin
                if (to_prio) begin
                    push_prio = advance && !prio_stat.full;
                    n_status  = prio_stat.full ? ST_DROPPED : ST_ADD_PRIO;
                end else begin
                    push_reg  = advance && !reg_stat.full;
                    n_status  = reg_stat.full ? ST_DROPPED : ST_ADD_REG;
                end
            end
            ACT_SERVE: begin
                if (!prio_stat.empty) begin
                    pop_prio = advance;
                    n_status = ST_SERVE_PRIO;
                end else if (!reg_stat.empty) begin
                    pop_reg  = advance;
                    n_status = ST_SERVE_REG;
                end else begin
                    n_status = ST_NONE;
                end
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase
    end

    tcpq_fifo u_prio_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_prio),
        .i_wdata (new_entry),
        .i_pop   (pop_prio),
        .o_rdata (prio_rdata),
        .o_stat  (prio_stat)
    );

    tcpq_fifo u_reg_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_reg),
        .i_wdata (new_entry),
        .i_pop   (pop_reg),
        .o_rdata (reg_rdata),
        .o_stat  (reg_stat)
    );

    // Control registers: request and result valid flags, threshold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thresh    <= AGE_THRESHOLD_RESET;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_word;
        end
        if (advance) begin
            r_status    <= n_status;
            r_served    <= pop_prio || pop_reg;
            r_from_prio <= pop_prio;
        end
    end

    // The queue read registers hold the served entry; drop it to zero otherwise.
    assign served_entry = r_from_prio ? prio_rdata : reg_rdata;

    assign o_valid              = r_out_valid;
    assign o_word.status        = r_status;
    assign o_word.served_tag    = r_served ? served_entry.tag : '0;
    assign o_word.served_age    = r_served ? served_entry.age : '0;
    assign o_word.served_urgent = r_served && served_entry.urgent;

endmodule

[src/tcpq_fifo.sv]
// One circular queue: head pointer, fill count and entry memory with registered read.
module tcpq_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tcpq_pkg::t_entry    i_wdata,
    input  logic                i_pop,
    output tcpq_pkg::t_entry    o_rdata,
    output tcpq_pkg::t_fifo_stat o_stat
);
    import tcpq_pkg::*;

    localparam int SUM_W = PTR_W + 1;

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rdata;
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_head;
    logic [CNT_W-1:0]   n_count;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_rdata      = r_rdata;

    // Tail is head plus count, wrapped once; count is below depth whenever it is used.
    always_comb begin
        tail_sum = {1'b0, r_head} + {1'b0, r_count[PTR_W-1:0]};
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // Never pop an empty queue or push a full one; count stays within depth.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not advance count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("count beyond depth");

endmodule

[dv/tcpq_order_check.sv]
// Prediction and comparison of result words for the two-class priority queue.
`timescale 1ns / 1ps

module tcpq_order_check
    import tcpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  t_in_word   i_req_word,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_stall,
    input  t_out_word  i_rsp_word,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_waiting,
    output int         o_drop_count
);

    logic [AGE_W-1:0] threshold_q;
    t_entry           prio_fifo[$];
    t_entry           reg_fifo[$];
    t_out_word        owed_results[$];

    // Classify or serve one request word and return the result word it owes.
    function automatic t_out_word schedule_word(input t_in_word w);
        t_out_word r;
        t_entry    e;
        r = '0;
        e.tag    = w.client_tag;
        e.age    = w.client_age;
        e.urgent = w.urgent;
        if (w.action == ACT_ADD) begin
            if (w.urgent || (w.client_age >= threshold_q)) begin
                if (prio_fifo.size() < QUEUE_DEPTH) begin
                    prio_fifo.push_back(e);
                    r.status = ST_ADD_PRIO;
                end else begin
                    r.status = ST_DROPPED;
                end
            end else if (reg_fifo.size() < QUEUE_DEPTH) begin
                reg_fifo.push_back(e);
                r.status = ST_ADD_REG;
            end else begin
                r.status = ST_DROPPED;
            end
        end else begin
            if (prio_fifo.size() != 0) begin
                e = prio_fifo.pop_front();
                r.status = ST_SERVE_PRIO;
            end else if (reg_fifo.size() != 0) begin
                e = reg_fifo.pop_front();
                r.status = ST_SERVE_REG;
            end else begin
                r.status = ST_NONE;
            end
            if (r.status != ST_NONE) begin
                r.served_tag    = e.tag;
                r.served_age    = e.age;
                r.served_urgent = e.urgent;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            prio_fifo.delete();
            reg_fifo.delete();
            owed_results.delete();
            threshold_q = AGE_THRESHOLD_RESET;
        end else begin
            if (i_cfg_we) begin
                threshold_q = i_cfg_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                owed_results.push_back(schedule_word(i_req_word));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("result word with nothing owed", 32'(i_rsp_word), 32'd0);
                end else begin
                    want = owed_results.pop_front();
                    if (want.status == ST_DROPPED) begin
                        o_drop_count++;
                    end
                    if (i_rsp_word.status !== want.status) begin
                        flag_mismatch("status", 32'(i_rsp_word.status), 32'(want.status));
                    end
                    if (i_rsp_word.served_tag !== want.served_tag) begin
                        flag_mismatch("served_tag", 32'(i_rsp_word.served_tag),
                                      32'(want.served_tag));
                    end
                    if (i_rsp_word.served_age !== want.served_age) begin
                        flag_mismatch("served_age", 32'(i_rsp_word.served_age),
                                      32'(want.served_age));
                    end
                    if (i_rsp_word.served_urgent !== want.served_urgent) begin
                        flag_mismatch("served_urgent", 32'(i_rsp_word.served_urgent),
                                      32'(want.served_urgent));
                    end
                end
            end
        end
        o_waiting <= owed_results.size();
    end

endmodule

[dv/tb_top.sv]
// Top of the two-class priority queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import tcpq_pkg::*;

    localparam int CLK_HALF        = 6;       // 12 ns period
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run
    localparam int HOLD_OFF_CYCLES = 80;      // long enough to back the block up
    localparam int IDLE_PCT        = 26;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    t_in_word   req_word;
    logic       req_stall;
    logic       rsp_valid;
    t_out_word  rsp_word;
    logic       rsp_stall;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    int fail_count;
    int waiting;
    int drop_count;

    // Stimulus knobs shared between the sender and the receiver.
    bit         tx_gaps;
    bit         rx_gaps;
    bit         hold_off_req;
    logic [7:0] cur_threshold;
    int         words_sent;
    int         cycle_count;

    two_class_priority_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .i_word      (req_word),
        .o_stall     (req_stall),
        .o_valid     (rsp_valid),
        .o_word      (rsp_word),
        .i_stall     (rsp_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tcpq_order_check u_order_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req_word   (req_word),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp_word   (rsp_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_drop_count (drop_count)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Build one request word from its fields.
    function automatic t_in_word build_word(input logic act, input logic [15:0] tag,
                                            input logic [7:0] age, input logic urg);
        t_in_word w;
        w.action     = act;
        w.client_tag = tag;
        w.client_age = age;
        w.urgent     = urg;
        return w;
    endfunction

    // Draw a random word; ages cluster on the extremes and around the live
    // threshold so that both sides of the compare get hit often.
    function automatic t_in_word random_word(input int add_pct);
        int         a;
        logic       act;
        logic [7:0] age;
        act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_SERVE;
        case ($urandom_range(5))
            0: begin
                age = 8'd0;
            end
            1: begin
                age = 8'd255;
            end
            2, 3: begin
                a = int'(cur_threshold) + int'($urandom_range(2)) - 1;
                if (a < 0) a = 0;
                if (a > 255) a = 255;
                age = a[7:0];
            end
            default: begin
                age = 8'($urandom_range(255));
            end
        endcase
        return build_word(act, 16'($urandom_range(16'hffff)), age,
                          $urandom_range(99) < 30);
    endfunction

    // Offer one word and hold it until the block takes it. Idle cycles come
    // first, so valid stays high across back-to-back words.
    task automatic send_word(input t_in_word w);
        while (tx_gaps && ($urandom_range(99) < IDLE_PCT)) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Run bursts of random words: add-heavy bursts fill the queues past full,
    // serve-heavy bursts drain them to empty, mixed bursts keep heads wrapping.
    task automatic run_traffic(input int n_words);
        int left;
        int burst;
        int add_pct;
        left = n_words;
        while (left > 0) begin
            burst = $urandom_range(40, 4);
            if (burst > left) burst = left;
            case ($urandom_range(2))
                0:       add_pct = 85;
                1:       add_pct = 15;
                default: add_pct = 50;
            endcase
            repeat (burst) send_word(random_word(add_pct));
            left -= burst;
        end
    endtask

    // Drop valid and wait until every owed result has come back, then let the
    // two-stage pipeline settle.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the threshold; only called with the block idle.
    task automatic write_threshold(input logic [7:0] value);
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        cur_threshold  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stall, or one long hold-off when the sender asks.
    initial begin
        rsp_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end else begin
                rsp_stall <= rx_gaps && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count, waiting);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        req_valid    <= 1'b0;
        req_word     <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        rst_n        <= 1'b0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_off_req  = 1'b0;
        words_sent    = 0;
        cur_threshold = AGE_THRESHOLD_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words against the reset threshold: serve on empty, field
        // extremes, ages just either side of the threshold, urgent below the
        // threshold, then drain in strict priority order down to empty.
        send_word(build_word(ACT_SERVE, 16'h0000, 8'd0, 1'b0));
        send_word(build_word(ACT_ADD, 16'h0000, 8'd0, 1'b0));
        send_word(build_word(ACT_ADD, 16'hffff, 8'd255, 1'b0));
        send_word(build_word(ACT_ADD, 16'h1234, 8'd60, 1'b0));
        send_word(build_word(ACT_ADD, 16'h5678, 8'd59, 1'b0));
        send_word(build_word(ACT_ADD, 16'h00ff, 8'd0, 1'b1));
        send_word(build_word(ACT_ADD, 16'hff00, 8'd59, 1'b1));
        repeat (7) send_word(build_word(ACT_SERVE, 16'hffff, 8'd255, 1'b1));
        wait_drained();

        // Threshold zero sends every add to the priority queue.
        write_threshold(8'd0);
        run_traffic(110);
        wait_drained();

        // Top threshold: only age 255 or urgent reaches priority.
        write_threshold(8'd255);
        run_traffic(110);
        wait_drained();

        // Long stretch with no idling on either side.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        write_threshold(8'($urandom_range(255)));
        run_traffic(130);
        wait_drained();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Back-pressure: hold the result side off while adds keep coming, so
        // the pipeline fills and the block stalls its request side.
        write_threshold(8'd100);
        hold_off_req = 1'b1;
        repeat (60) send_word(random_word(90));
        run_traffic(40);
        wait_drained();

        write_threshold(8'd1);
        run_traffic(110);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("covered %0d request words over six threshold settings incl. 0 and 255,",
                 words_sent);
        $display("%0d dropped adds on full queues and one %0d-cycle result hold-off",
                 drop_count, HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
